@@ hdl/aabc_pkg.sv @@
package aabc_pkg;

	localparam int MIN_LEVEL = 0;
	localparam int MAX_LEVEL = 255;

	localparam logic [31:0] UPDATE_MS   = 32'd250;
	localparam logic [31:0] SAMPLE_MS   = 32'd2000;
	localparam logic [31:0] DEBOUNCE_MS = 32'd10;
	localparam logic [9:0]  FADE_STEP   = 10'd8;
	localparam logic signed [14:0] EMA_WEIGHT = 15'sd13107;
	localparam logic [11:0] RAW_FULL    = 12'd4095;

	localparam logic signed [10:0] MIN_LEVEL_S = 11'(MIN_LEVEL);
	localparam logic signed [10:0] MAX_LEVEL_S = 11'(MAX_LEVEL);

	typedef enum logic [2:0] {
		CFG_AUTO_ENABLE  = 3'd0,
		CFG_NIGHT_LEVEL  = 3'd1,
		CFG_DAY_LEVEL    = 3'd2,
		CFG_NIGHT_START  = 3'd3,
		CFG_NIGHT_END    = 3'd4,
		CFG_MIN_SWING    = 3'd5,
		CFG_HOLD_MS      = 3'd6,
		CFG_DARK_IS_HIGH = 3'd7
	} cfg_idx_t;

	typedef enum logic {
		OP_AUTO_TICK = 1'b0,
		OP_TOUCH     = 1'b1
	} op_t;

	typedef struct packed {
		logic        auto_enable;
		logic [7:0]  night_level;
		logic [7:0]  day_level;
		logic [4:0]  night_start_hour;
		logic [4:0]  night_end_hour;
		logic [11:0] min_swing;
		logic [31:0] hold_ms;
		logic        dark_is_high;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] now_ms;
		logic [11:0] light_raw;
		logic [4:0]  local_hour;
		logic        hour_known;
		logic [8:0]  step_delta;
	} item_t;

	typedef struct packed {
		logic        trusted;
		logic        dark;
		logic        seen;
		logic [11:0] light;
	} sens_t;

	typedef struct packed {
		logic [7:0]  level;
		logic        level_written;
		logic        show_bar;
		logic        sensor_trusted;
		logic        room_dark;
		logic        smoothed_valid;
		logic [11:0] smoothed_light;
		logic [31:0] hold_remaining_ms;
	} res_t;

	function automatic logic [7:0] clamp_level(input logic signed [10:0] v);
		logic signed [10:0] r;
		r = v;
		if (r < MIN_LEVEL_S) r = MIN_LEVEL_S;
		if (r > MAX_LEVEL_S) r = MAX_LEVEL_S;
		return r[7:0];
	endfunction

endpackage

@@ hdl/aabc_sensor.sv @@
module aabc_sensor
	import aabc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        run,
	input  logic [31:0] now_ms,
	input  logic [11:0] light_raw,
	input  logic        dark_is_high,
	input  logic [11:0] min_swing,
	output sens_t       sens
);

	logic [31:0] last_sample_q;
	logic [27:0] smooth_q;
	logic        seen_q;
	logic [11:0] min_q;
	logic [11:0] max_q;
	logic        dark_q;

	logic               do_sample;
	logic [11:0]        sample;
	logic [27:0]        sample_fx;
	logic signed [28:0] diff;
	logic signed [43:0] prod;
	logic signed [43:0] adj;
	logic [27:0]        smooth_d;
	logic [11:0]        e;
	logic [11:0]        min_n;
	logic [11:0]        max_n;
	logic signed [12:0] range;
	logic               trusted_n;
	logic [12:0]        mid_sum;
	logic [11:0]        mid;
	logic [8:0]         band;
	logic signed [13:0] hi;
	logic signed [13:0] lo;
	logic signed [13:0] e_s;
	logic               dark_n;

	always_comb begin
		do_sample = run && ((now_ms - last_sample_q) >= SAMPLE_MS);
		sample    = dark_is_high ? light_raw : RAW_FULL - light_raw;
		sample_fx = {sample, 16'd0};
		diff      = $signed({1'b0, sample_fx}) - $signed({1'b0, smooth_q});
		prod      = diff * EMA_WEIGHT;
		adj       = prod >>> 16;
		smooth_d  = seen_q ? smooth_q + adj[27:0] : sample_fx;
		e         = smooth_d[27:16];
		min_n     = min_q;
		max_n     = max_q;
		if (do_sample) begin
			if (e < min_q) min_n = e;
			if (e > max_q) max_n = e;
		end
		range     = $signed({1'b0, max_n}) - $signed({1'b0, min_n});
		trusted_n = range >= $signed({1'b0, min_swing});
		mid_sum   = {1'b0, min_n} + {1'b0, max_n};
		mid       = mid_sum[12:1];
		band      = range[11:3];
		hi        = $signed({2'b0, mid}) + $signed({5'b0, band});
		lo        = $signed({2'b0, mid}) - $signed({5'b0, band});
		e_s       = $signed({2'b0, e});
		dark_n    = dark_q;
		if (do_sample && trusted_n) begin
			if (!dark_q && e_s > hi) dark_n = 1'b1;
			else if (dark_q && e_s < lo) dark_n = 1'b0;
		end
		sens.trusted = trusted_n;
		sens.dark    = dark_n;
		sens.seen    = seen_q || do_sample;
		sens.light   = do_sample ? e : smooth_q[27:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= '0;
			smooth_q      <= '0;
			seen_q        <= 1'b0;
			min_q         <= RAW_FULL;
			max_q         <= '0;
			dark_q        <= 1'b0;
		end else if (advance && do_sample) begin
			last_sample_q <= now_ms;
			smooth_q      <= smooth_d;
			seen_q        <= 1'b1;
			min_q         <= min_n;
			max_q         <= max_n;
			dark_q        <= dark_n;
		end
	end

endmodule

@@ hdl/aabc_ctrl.sv @@
module aabc_ctrl
	import aabc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  advance,
	input  item_t item,
	input  cfg_t  cfg,
	input  sens_t sens,
	output logic  run,
	output res_t  result
);

	logic [7:0]  level_q;
	logic        hold_q;
	logic [31:0] hold_start_q;
	logic [31:0] last_update_q;
	logic [31:0] last_step_q;

	logic               hold_act;
	logic               touch_ok;
	logic [7:0]         night_t;
	logic [7:0]         day_t;
	logic               in_window;
	logic               target_ok;
	logic [7:0]         target;
	logic [9:0]         up_lvl;
	logic signed [9:0]  dn_lvl;
	logic [7:0]         fade_lvl;
	logic               auto_wr;
	logic [7:0]         touch_lvl;
	logic [7:0]         level_d;
	logic               hold_mid;
	logic [31:0]        start_mid;
	logic [31:0]        elapsed_mid;
	logic               hold_fin;

	always_comb begin
		hold_act = hold_q && !((item.now_ms - hold_start_q) >= cfg.hold_ms);
		touch_ok = (item.op == OP_TOUCH) && ((item.now_ms - last_step_q) > DEBOUNCE_MS);
		run      = (item.op == OP_AUTO_TICK) && !hold_act
		           && ((item.now_ms - last_update_q) >= UPDATE_MS);

		night_t = clamp_level($signed({3'b0, cfg.night_level}));
		day_t   = clamp_level($signed({3'b0, cfg.day_level}));

		if (cfg.night_start_hour == cfg.night_end_hour) in_window = 1'b0;
		else if (cfg.night_start_hour < cfg.night_end_hour)
			in_window = (item.local_hour >= cfg.night_start_hour)
			            && (item.local_hour < cfg.night_end_hour);
		else
			in_window = (item.local_hour >= cfg.night_start_hour)
			            || (item.local_hour < cfg.night_end_hour);

		target_ok = 1'b1;
		if (!cfg.auto_enable) target = day_t;
		else if (sens.trusted) target = sens.dark ? night_t : day_t;
		else begin
			target    = in_window ? night_t : day_t;
			target_ok = item.hour_known;
		end

		up_lvl = {2'b0, level_q} + FADE_STEP;
		dn_lvl = $signed({2'b0, level_q}) - $signed(FADE_STEP);
		if (level_q < target)
			fade_lvl = (up_lvl > {2'b0, target}) ? target : up_lvl[7:0];
		else
			fade_lvl = (dn_lvl < $signed({2'b0, target})) ? target : dn_lvl[7:0];
		auto_wr = run && target_ok && (level_q != target);

		touch_lvl = clamp_level($signed({3'b0, level_q})
		                        + $signed({{2{item.step_delta[8]}}, item.step_delta}));

		if (touch_ok) level_d = touch_lvl;
		else if (auto_wr) level_d = fade_lvl;
		else level_d = level_q;

		hold_mid    = touch_ok || ((item.op == OP_TOUCH) ? hold_q : hold_act);
		start_mid   = touch_ok ? item.now_ms : hold_start_q;
		elapsed_mid = item.now_ms - start_mid;
		hold_fin    = hold_mid && !(elapsed_mid >= cfg.hold_ms);

		result.level             = level_d;
		result.level_written     = touch_ok || auto_wr;
		result.show_bar          = touch_ok;
		result.sensor_trusted    = sens.trusted;
		result.room_dark         = sens.dark;
		result.smoothed_valid    = sens.seen;
		result.smoothed_light    = sens.light;
		result.hold_remaining_ms = hold_fin ? cfg.hold_ms - elapsed_mid : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= 8'd80;
			hold_q        <= 1'b0;
			hold_start_q  <= '0;
			last_update_q <= '0;
			last_step_q   <= '0;
		end else if (advance) begin
			level_q      <= level_d;
			hold_q       <= hold_fin;
			hold_start_q <= start_mid;
			if (run) last_update_q <= item.now_ms;
			if (touch_ok) last_step_q <= item.now_ms;
		end
	end

endmodule

@@ hdl/ambient_auto_brightness_controller.sv @@
// an accepted input word passes through the input register and then the result register before the result word is valid
// accepts one input word per cycle, stalling only when the result word is not taken
// config writes are registered, cfg_ready is always high
// arst_n low clears all control state, config registers return to defaults
// an auto tick or touch updates controller state when it moves into the result register
module ambient_auto_brightness_controller
	import aabc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// now_ms, light_raw, local_hour, hour_known, step_delta, zero pad
	input  logic [63:0] s_axis_tdata,
	// op
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// level, level_written, show_bar, sensor_trusted, room_dark,
	// smoothed_valid, smoothed_light, hold_remaining_ms, zero pad
	output logic [63:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_q;
	logic  out_valid_q;

	logic  advance;
	logic  run;
	sens_t sens;
	res_t  result;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_enable      <= 1'b1;
			cfg_q.night_level      <= 8'd20;
			cfg_q.day_level        <= 8'd80;
			cfg_q.night_start_hour <= 5'd1;
			cfg_q.night_end_hour   <= 5'd7;
			cfg_q.min_swing        <= 12'd400;
			cfg_q.hold_ms          <= 32'd60000;
			cfg_q.dark_is_high     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_AUTO_ENABLE:  cfg_q.auto_enable      <= cfg_data[0];
				CFG_NIGHT_LEVEL:  cfg_q.night_level      <= cfg_data[7:0];
				CFG_DAY_LEVEL:    cfg_q.day_level        <= cfg_data[7:0];
				CFG_NIGHT_START:  cfg_q.night_start_hour <= cfg_data[4:0];
				CFG_NIGHT_END:    cfg_q.night_end_hour   <= cfg_data[4:0];
				CFG_MIN_SWING:    cfg_q.min_swing        <= cfg_data[11:0];
				CFG_HOLD_MS:      cfg_q.hold_ms          <= cfg_data;
				CFG_DARK_IS_HIGH: cfg_q.dark_is_high     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.op         <= op_t'(s_axis_tuser);
			item_s1.now_ms     <= s_axis_tdata[31:0];
			item_s1.light_raw  <= s_axis_tdata[43:32];
			item_s1.local_hour <= s_axis_tdata[48:44];
			item_s1.hour_known <= s_axis_tdata[49];
			item_s1.step_delta <= s_axis_tdata[58:50];
		end
	end

	aabc_sensor u_sensor (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.run          (run),
		.now_ms       (item_s1.now_ms),
		.light_raw    (item_s1.light_raw),
		.dark_is_high (cfg_q.dark_is_high),
		.min_swing    (cfg_q.min_swing),
		.sens         (sens)
	);

	aabc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.sens    (sens),
		.run     (run),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0,
	                        res_q.hold_remaining_ms,
	                        res_q.smoothed_light,
	                        res_q.smoothed_valid,
	                        res_q.room_dark,
	                        res_q.sensor_trusted,
	                        res_q.show_bar,
	                        res_q.level_written,
	                        res_q.level};

endmodule

@@ hdl/aabc_checker.sv @@
module aabc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// the overlay request only comes with a level write
	a_bar_written: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[8])
		else $error("show_bar without level_written");

	// no sample yet means no smoothed value, no trust and no dark room
	a_unseen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[12] |-> m_axis_tdata[24:13] == 12'd0
		&& !m_axis_tdata[10] && !m_axis_tdata[11])
		else $error("sensor state before first sample");

	// an accepted word passes the input and result registers and shows up at the output when nothing stalls
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("result word missing");

endmodule

bind ambient_auto_brightness_controller aabc_checker u_aabc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
